// ----- rtl/itrp_pkg.sv -----
package itrp_pkg;

  // Parser phases; codes above the error phase cannot arise and read as errors
  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_TAG        = 4'd1,
    PH_COND       = 4'd2,
    PH_TEXT_START = 4'd3,
    PH_CODE       = 4'd4,
    PH_TEXT       = 4'd5,
    PH_CRLF       = 4'd6,
    PH_LF         = 4'd7,
    PH_ERROR      = 4'd8
  } phase_t;

  // Role reported for each byte
  typedef enum logic [2:0] {
    ROLE_TAG  = 3'd0,
    ROLE_SEP  = 3'd1,
    ROLE_COND = 3'd2,
    ROLE_CODE = 3'd3,
    ROLE_TEXT = 3'd4,
    ROLE_EOL  = 3'd5,
    ROLE_ERR  = 3'd6
  } role_t;

  // Condition word of the response
  typedef enum logic [1:0] {
    COND_OK  = 2'd0,
    COND_NO  = 2'd1,
    COND_BAD = 2'd2
  } cond_t;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_CTL_MAX = 8'h1F;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;

  // Width of the packed result word
  localparam int OUT_DATA_W = 16;

  // Tag characters: astring characters other than the plus sign
  function automatic logic is_tag_char(input logic [7:0] c);
    logic r;
    r = 1'b1;
    if (c == CH_RBRK) begin
      r = 1'b1;
    end else if (c <= CH_CTL_MAX || c >= CH_DEL) begin
      r = 1'b0;
    end else begin
      case (c) inside
        CH_LPAR, CH_RPAR, CH_LBRC, CH_SP, CH_BSL, CH_DQUOTE, CH_PCT, CH_STAR, CH_PLUS: begin
          r = 1'b0;
        end
        default: begin
          r = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // Text characters: 0x02 to 0x7F without CR and LF
  function automatic logic is_body_char(input logic [7:0] c);
    return (c > CH_SOH) && (c <= CH_DEL) && (c != CH_CR) && (c != CH_LF);
  endfunction

  // Number of letters in each condition word
  function automatic logic [1:0] cond_length(input cond_t w);
    logic [1:0] n;
    case (w)
      COND_BAD: n = 2'd3;
      default:  n = 2'd2;
    endcase
    return n;
  endfunction

  // Expected letter at a given place of a condition word
  function automatic logic [7:0] cond_letter(input cond_t w, input logic [1:0] idx);
    logic [7:0] l;
    l = 8'h00;
    case (w)
      COND_OK: begin
        case (idx)
          2'd0:    l = CH_O;
          2'd1:    l = CH_K;
          default: l = 8'h00;
        endcase
      end
      COND_NO: begin
        case (idx)
          2'd0:    l = CH_N;
          2'd1:    l = CH_O;
          default: l = 8'h00;
        endcase
      end
      COND_BAD: begin
        case (idx)
          2'd0:    l = CH_B;
          2'd1:    l = CH_A;
          2'd2:    l = CH_D;
          default: l = 8'h00;
        endcase
      end
      default: l = 8'h00;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/imap_tagged_response_parser_top.sv -----
// Tagged IMAP response line parser. Server bytes enter on the in_ stream one word per
// byte; every byte yields exactly one result word on the out_ stream, giving the role of
// the byte, the marks where the tag, the condition word, the text and the line end, the
// latest condition word (OK, NO or BAD) and a fault flag. A line starting with '+' or
// '*', and any other violation of the line form, puts the parser into a fault state that
// only rst_n clears. The block takes one byte per clock while the out_ side is not stalled: a
// byte passes an input register, the combinational next-state logic of the parser and a
// result register, and a stalled out_ side holds the input side back only once both
// registers are full.
module imap_tagged_response_parser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] data_byte
  input  logic [7:0]                          in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] byte_role, [3] tag_done, [4] cond_done, [6:5] cond_kind, [7] text_done,
  // [8] line_done, [9] parse_fault, [15:10] zero
  output logic [itrp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic                                s1_valid_r;
  logic [7:0]                          s1_data_r;
  logic                                out_valid_r;
  logic [itrp_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic                                proc;

  itrp_pkg::phase_t                    phase_r, phase_nxt;
  logic [1:0]                          cc_r, cc_nxt;
  itrp_pkg::cond_t                     cw_r, cw_nxt;
  logic                                ret_crlf_r, ret_crlf_nxt;
  logic                                prev_br_r;

  logic [7:0]                          c;
  logic [1:0]                          cc_eff;
  logic [1:0]                          cc_inc;
  logic                                err;
  itrp_pkg::role_t                     role;
  logic                                tag_d, cond_d, text_d, line_d, fault;
  logic [itrp_pkg::OUT_DATA_W-1:0]     res_word;

  assign c         = s1_data_r;
  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;

  // Count used by the tag and text steps; it starts at zero on entry to either
  always_comb begin
    if (phase_r == itrp_pkg::PH_START || phase_r == itrp_pkg::PH_TEXT_START) begin
      cc_eff = 2'd0;
    end else begin
      cc_eff = cc_r;
    end
    cc_inc = (cc_eff == 2'd3) ? 2'd3 : cc_eff + 2'd1;
  end

  // Next state and per-byte result of the parser
  always_comb begin
    phase_nxt    = phase_r;
    cc_nxt       = cc_r;
    cw_nxt       = cw_r;
    ret_crlf_nxt = ret_crlf_r;
    role         = itrp_pkg::ROLE_ERR;
    tag_d        = 1'b0;
    cond_d       = 1'b0;
    text_d       = 1'b0;
    line_d       = 1'b0;
    fault        = 1'b0;
    err          = 1'b0;
    unique case (phase_r) inside
      itrp_pkg::PH_START, itrp_pkg::PH_TAG: begin
        if (phase_r == itrp_pkg::PH_START &&
            (c == itrp_pkg::CH_PLUS || c == itrp_pkg::CH_STAR)) begin
          err = 1'b1;
        end else if (itrp_pkg::is_tag_char(c)) begin
          cc_nxt    = cc_inc;
          phase_nxt = itrp_pkg::PH_TAG;
          role      = itrp_pkg::ROLE_TAG;
        end else if (cc_eff == 2'd0 || c != itrp_pkg::CH_SP) begin
          err = 1'b1;
        end else begin
          tag_d        = 1'b1;
          role         = itrp_pkg::ROLE_SEP;
          phase_nxt    = itrp_pkg::PH_COND;
          ret_crlf_nxt = 1'b1;
          cc_nxt       = 2'd0;
        end
      end
      itrp_pkg::PH_COND: begin
        if (cc_r == 2'd0) begin
          if (c == itrp_pkg::CH_O) begin
            cw_nxt = itrp_pkg::COND_OK;
            cc_nxt = 2'd1;
            role   = itrp_pkg::ROLE_COND;
          end else if (c == itrp_pkg::CH_N) begin
            cw_nxt = itrp_pkg::COND_NO;
            cc_nxt = 2'd1;
            role   = itrp_pkg::ROLE_COND;
          end else if (c == itrp_pkg::CH_B) begin
            cw_nxt = itrp_pkg::COND_BAD;
            cc_nxt = 2'd1;
            role   = itrp_pkg::ROLE_COND;
          end else begin
            err = 1'b1;
          end
        end else if (cw_r != itrp_pkg::COND_OK && cw_r != itrp_pkg::COND_NO &&
                     cw_r != itrp_pkg::COND_BAD) begin
          err = 1'b1;
        end else if (cc_r >= itrp_pkg::cond_length(cw_r)) begin
          if (c == itrp_pkg::CH_SP) begin
            cond_d    = 1'b1;
            role      = itrp_pkg::ROLE_SEP;
            phase_nxt = itrp_pkg::PH_TEXT_START;
            cc_nxt    = 2'd0;
          end else begin
            err = 1'b1;
          end
        end else if (c == itrp_pkg::cond_letter(cw_r, cc_r)) begin
          cc_nxt = cc_r + 2'd1;
          role   = itrp_pkg::ROLE_COND;
        end else begin
          err = 1'b1;
        end
      end
      itrp_pkg::PH_TEXT_START, itrp_pkg::PH_TEXT: begin
        if (phase_r == itrp_pkg::PH_TEXT_START && c == itrp_pkg::CH_LBRK) begin
          cc_nxt    = 2'd0;
          phase_nxt = itrp_pkg::PH_CODE;
          role      = itrp_pkg::ROLE_CODE;
        end else if (itrp_pkg::is_body_char(c)) begin
          cc_nxt    = cc_inc;
          phase_nxt = itrp_pkg::PH_TEXT;
          role      = itrp_pkg::ROLE_TEXT;
        end else if (cc_eff == 2'd0 || !ret_crlf_r) begin
          err = 1'b1;
        end else begin
          text_d = 1'b1;
          cc_nxt = 2'd0;
          if (c == itrp_pkg::CH_CR) begin
            phase_nxt = itrp_pkg::PH_LF;
            role      = itrp_pkg::ROLE_EOL;
          end else if (c == itrp_pkg::CH_LF) begin
            phase_nxt = itrp_pkg::PH_START;
            role      = itrp_pkg::ROLE_EOL;
            line_d    = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      itrp_pkg::PH_CODE: begin
        if (prev_br_r && c == itrp_pkg::CH_SP) begin
          phase_nxt = itrp_pkg::PH_TEXT;
          cc_nxt    = 2'd0;
          role      = itrp_pkg::ROLE_SEP;
        end else begin
          role = itrp_pkg::ROLE_CODE;
        end
      end
      itrp_pkg::PH_CRLF, itrp_pkg::PH_LF: begin
        if (phase_r == itrp_pkg::PH_CRLF && c == itrp_pkg::CH_CR) begin
          phase_nxt = itrp_pkg::PH_LF;
          role      = itrp_pkg::ROLE_EOL;
        end else if (c == itrp_pkg::CH_LF) begin
          phase_nxt = itrp_pkg::PH_START;
          role      = itrp_pkg::ROLE_EOL;
          line_d    = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    // Any violation lands in the sticky fault state with all marks cleared
    if (err) begin
      phase_nxt = itrp_pkg::PH_ERROR;
      role      = itrp_pkg::ROLE_ERR;
      fault     = 1'b1;
      tag_d     = 1'b0;
      cond_d    = 1'b0;
      text_d    = 1'b0;
      line_d    = 1'b0;
    end
  end

  // Pack the result word
  assign res_word = {{(itrp_pkg::OUT_DATA_W - 10){1'b0}}, fault, line_d, text_d,
                     logic'(cw_nxt[1]), logic'(cw_nxt[0]), cond_d, tag_d, role};

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  // Parser state, updated once for every byte processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= itrp_pkg::PH_START;
      cc_r       <= 2'd0;
      cw_r       <= itrp_pkg::COND_OK;
      ret_crlf_r <= 1'b0;
      prev_br_r  <= 1'b0;
    end else if (proc) begin
      phase_r    <= phase_nxt;
      cc_r       <= cc_nxt;
      cw_r       <= cw_nxt;
      ret_crlf_r <= ret_crlf_nxt;
      prev_br_r  <= (c == itrp_pkg::CH_RBRK);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
    if (proc) begin
      out_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Fault state is sticky until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == itrp_pkg::PH_ERROR |=> phase_r == itrp_pkg::PH_ERROR)
    else $error("parser left the fault state without reset");

  // A fault result carries the error role
  a_fault_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[9] |-> out_data_r[2:0] == itrp_pkg::ROLE_ERR)
    else $error("fault word without error role");

  // A completed line is reported on a line-end byte
  a_line_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[8] |-> out_data_r[2:0] == itrp_pkg::ROLE_EOL)
    else $error("line end marked on a byte that is not a line end");

  // Tag, condition and line marks never coincide
  a_marks_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_data_r[3], out_data_r[4], out_data_r[8]}))
    else $error("several token-end marks on one byte");

  // Text is only reached after a tag has armed the line-end check
  a_text_armed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == itrp_pkg::PH_TEXT |-> ret_crlf_r)
    else $error("text phase without a preceding tag");

endmodule
